>>> rtl/mct_pkg.sv
// shared types, codes and helpers for the mm:ss countdown timer with lockout
// no dependencies

package mct_pkg;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_DATA_W  = 24;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BEEP         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_HALF   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHASE_STEP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_S  = 3'd4;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd1500;
    localparam logic [CFG_W-1:0] BEEP_RST        = 16'd400;
    localparam logic [CFG_W-1:0] BLINK_HALF_RST  = 16'd500;
    localparam logic [CFG_W-1:0] CHASE_STEP_RST  = 16'd201;
    localparam logic [CFG_W-1:0] TICKS_PER_S_RST = 16'd1000;

    // digit ranges
    localparam logic [3:0] DIGIT_MAX     = 4'd9;
    localparam logic [3:0] SEC_TENS_MAX  = 4'd5;
    localparam logic [1:0] SEC_TENS_POS  = 2'd2;
    localparam logic [2:0] CURSOR_LAST   = 3'd4;

    typedef enum logic [2:0] {
        KEY_NONE,
        KEY_ONE,
        KEY_TWO,
        KEY_THREE_SHORT,
        KEY_THREE_LONG
    } key_t;

    typedef struct packed {
        logic [CFG_W-1:0] beep_ticks;
        logic [CFG_W-1:0] blink_half_ticks;
        logic [CFG_W-1:0] chase_step_ticks;
        logic [CFG_W-1:0] ticks_per_second;
    } timer_cfg_t;

    typedef struct packed {
        logic [3:0] minutes_tens;
        logic [3:0] minutes_ones;
        logic [2:0] seconds_tens;
        logic [3:0] seconds_ones;
        logic [2:0] blanked_digit;
        logic [3:0] leds_lit;
        logic       beeper_on;
        logic       counting;
    } result_t;

    // top value of the digit at a position (seconds tens stops at five)
    function automatic logic [3:0] digit_limit(input logic [1:0] pos);
        digit_limit = (pos == SEC_TENS_POS) ? SEC_TENS_MAX : DIGIT_MAX;
    endfunction

endpackage

>>> rtl/mct_keys.sv
// key press decoder: new-press detection and short/long key-3 timing
// depends on mct_pkg

module mct_keys
    import mct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             key_one_down,
    input  logic             key_two_down,
    input  logic             key_three_down,
    input  logic [CFG_W-1:0] long_press_ticks,
    output key_t             key
);

    logic             keys_released_reg, keys_released_next;
    logic             long_seen_reg, long_seen_next;
    logic             held_reg, held_next;
    logic [CFG_W-1:0] hold_reg, hold_next;

    always_comb
    begin
        logic any_down;
        any_down           = key_one_down | key_two_down | key_three_down;
        key                = KEY_NONE;
        keys_released_next = keys_released_reg;
        long_seen_next     = long_seen_reg;
        held_next          = held_reg;
        hold_next          = hold_reg;

        if (keys_released_reg && any_down)
        begin
            keys_released_next = 1'b0;
            long_seen_next     = 1'b0;
            if (key_one_down)
                key = KEY_ONE;
            else if (key_two_down)
                key = KEY_TWO;
            else
            begin
                held_next = 1'b1;
                hold_next = '0;
            end
        end
        else if (!any_down)
        begin
            keys_released_next = 1'b1;
            if (held_reg && (hold_reg < long_press_ticks) && !long_seen_reg)
                key = KEY_THREE_SHORT;
            held_next = 1'b0;
        end

        if (held_next && (hold_next >= long_press_ticks) && !long_seen_next)
        begin
            key            = KEY_THREE_LONG;
            long_seen_next = 1'b1;
        end

        // hold time saturates
        if (held_next && (hold_next != '1))
            hold_next = hold_next + CFG_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_released_reg <= 1'b1;
            long_seen_reg     <= 1'b0;
            held_reg          <= 1'b0;
            hold_reg          <= '0;
        end
        else if (en)
        begin
            keys_released_reg <= keys_released_next;
            long_seen_reg     <= long_seen_next;
            held_reg          <= held_next;
            hold_reg          <= hold_next;
        end
    end

endmodule

>>> rtl/mct_core.sv
// timer core: digit edit, start/pause, contestant lockout, tick timers, countdown
// depends on mct_pkg

module mct_core
    import mct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  key_t       key,
    input  timer_cfg_t cfg,
    output result_t    result
);

    logic [3:0]       digit_reg [4];
    logic [3:0]       digit_next [4];
    logic [2:0]       cursor_reg, cursor_next;
    logic             run_reg, run_next;
    logic             armed_reg, armed_next;
    logic             started_reg, started_next;
    logic             finished_reg, finished_next;
    logic [1:0]       taken_reg, taken_next;
    logic [3:0]       led_reg, led_next;
    logic [CFG_W-1:0] beep_cnt_reg, beep_cnt_next;
    logic             beep_reg, beep_next;
    logic [CFG_W-1:0] blink_cnt_reg, blink_cnt_next;
    logic             blink_phase_reg, blink_phase_next;
    logic [CFG_W-1:0] chase_cnt_reg, chase_cnt_next;
    logic [1:0]       chase_idx_reg, chase_idx_next;
    logic [CFG_W-1:0] sec_cnt_reg, sec_cnt_next;

    always_comb
    begin
        logic [1:0] pos;
        logic       editing;
        logic       racing;
        logic       hit;
        logic       who;
        logic [3:0] cur_digit;

        pos       = cursor_reg[1:0] - 2'd1;
        editing   = !started_reg && !finished_reg;
        racing    = started_reg && armed_reg && !finished_reg;
        hit       = 1'b0;
        who       = 1'b0;
        cur_digit = digit_reg[pos];

        digit_next       = digit_reg;
        cursor_next      = cursor_reg;
        run_next         = run_reg;
        armed_next       = armed_reg;
        started_next     = started_reg;
        finished_next    = finished_reg;
        taken_next       = taken_reg;
        led_next         = led_reg;
        beep_cnt_next    = beep_cnt_reg;
        beep_next        = beep_reg;
        blink_cnt_next   = blink_cnt_reg;
        blink_phase_next = blink_phase_reg;
        chase_cnt_next   = chase_cnt_reg;
        chase_idx_next   = chase_idx_reg;
        sec_cnt_next     = sec_cnt_reg;

        unique case (key)
            KEY_ONE:
            begin
                if (editing)
                    cursor_next = (cursor_reg >= CURSOR_LAST) ? 3'd0 : cursor_reg + 3'd1;
                else if (racing)
                begin
                    hit = 1'b1;
                    who = 1'b0;
                end
            end
            KEY_TWO:
            begin
                if (editing)
                begin
                    if (cursor_reg != 3'd0)
                        digit_next[pos] = (cur_digit >= digit_limit(pos)) ?
                                          4'd0 : cur_digit + 4'd1;
                end
                else if (racing)
                begin
                    hit = 1'b1;
                    who = 1'b1;
                end
            end
            KEY_THREE_SHORT:
            begin
                if (cursor_reg == 3'd0)
                begin
                    started_next = 1'b1;
                    if (!armed_reg)
                    begin
                        // digits themselves hold the remaining time
                        taken_next = 2'b00;
                        run_next   = 1'b1;
                        armed_next = 1'b1;
                    end
                    else
                    begin
                        run_next   = 1'b0;
                        armed_next = 1'b0;
                        led_next   = 4'd0;
                    end
                end
                else
                    digit_next[pos] = (cur_digit == 4'd0) ? digit_limit(pos) : cur_digit - 4'd1;
            end
            KEY_THREE_LONG:
            begin
                for (int i = 0; i < 4; i++)
                    digit_next[i] = 4'd0;
                started_next  = 1'b0;
                beep_next     = 1'b0;
                run_next      = 1'b0;
                finished_next = 1'b0;
                armed_next    = 1'b0;
                cursor_next   = 3'd0;
                led_next      = 4'd0;
            end
            default:
            begin
            end
        endcase

        // first contestant locks out the other
        if (hit)
        begin
            taken_next[who] = 1'b1;
            if (!taken_reg[!who])
            begin
                run_next      = 1'b0;
                led_next      = led_next | (4'd1 << who);
                beep_cnt_next = cfg.beep_ticks;
                beep_next     = 1'b1;
            end
        end

        if (finished_next)
            led_next = 4'd1 << chase_idx_reg;

        blink_cnt_next = blink_cnt_reg + CFG_W'(1);
        if (blink_cnt_next >= cfg.blink_half_ticks)
        begin
            blink_cnt_next   = '0;
            blink_phase_next = !blink_phase_reg;
        end

        chase_cnt_next = chase_cnt_reg + CFG_W'(1);
        if (chase_cnt_next >= cfg.chase_step_ticks)
        begin
            chase_cnt_next = '0;
            chase_idx_next = chase_idx_reg + 2'd1;
        end

        if (beep_cnt_next != '0)
        begin
            beep_cnt_next = beep_cnt_next - CFG_W'(1);
            if (beep_cnt_next == '0)
                beep_next = 1'b0;
        end

        // countdown: one bcd step per second, mm:ss with a six-state seconds tens
        if (run_next)
        begin
            sec_cnt_next = sec_cnt_reg + CFG_W'(1);
            if (sec_cnt_next >= cfg.ticks_per_second)
            begin
                sec_cnt_next = '0;
                if ((digit_next[0] | digit_next[1] | digit_next[2] | digit_next[3]) != 4'd0)
                begin
                    if (digit_next[3] != 4'd0)
                        digit_next[3] = digit_next[3] - 4'd1;
                    else
                    begin
                        digit_next[3] = DIGIT_MAX;
                        if (digit_next[2] != 4'd0)
                            digit_next[2] = digit_next[2] - 4'd1;
                        else
                        begin
                            digit_next[2] = SEC_TENS_MAX;
                            if (digit_next[1] != 4'd0)
                                digit_next[1] = digit_next[1] - 4'd1;
                            else
                            begin
                                digit_next[1] = DIGIT_MAX;
                                digit_next[0] = digit_next[0] - 4'd1;
                            end
                        end
                    end
                end
                if ((digit_next[0] | digit_next[1] | digit_next[2] | digit_next[3]) == 4'd0)
                begin
                    beep_next     = 1'b1;
                    finished_next = 1'b1;
                    run_next      = 1'b0;
                end
            end
        end

        result.minutes_tens  = digit_next[0];
        result.minutes_ones  = digit_next[1];
        result.seconds_tens  = digit_next[2][2:0];
        result.seconds_ones  = digit_next[3];
        result.blanked_digit = (cursor_next != 3'd0 && !blink_phase_next) ? cursor_next : 3'd0;
        result.leds_lit      = led_next;
        result.beeper_on     = beep_next;
        result.counting      = run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                digit_reg[i] <= 4'd0;
            cursor_reg      <= 3'd0;
            run_reg         <= 1'b0;
            armed_reg       <= 1'b0;
            started_reg     <= 1'b0;
            finished_reg    <= 1'b0;
            taken_reg       <= 2'b00;
            led_reg         <= 4'd0;
            beep_cnt_reg    <= '0;
            beep_reg        <= 1'b0;
            blink_cnt_reg   <= '0;
            blink_phase_reg <= 1'b1;
            chase_cnt_reg   <= '0;
            chase_idx_reg   <= 2'd0;
            sec_cnt_reg     <= '0;
        end
        else if (en)
        begin
            digit_reg       <= digit_next;
            cursor_reg      <= cursor_next;
            run_reg         <= run_next;
            armed_reg       <= armed_next;
            started_reg     <= started_next;
            finished_reg    <= finished_next;
            taken_reg       <= taken_next;
            led_reg         <= led_next;
            beep_cnt_reg    <= beep_cnt_next;
            beep_reg        <= beep_next;
            blink_cnt_reg   <= blink_cnt_next;
            blink_phase_reg <= blink_phase_next;
            chase_cnt_reg   <= chase_cnt_next;
            chase_idx_reg   <= chase_idx_next;
            sec_cnt_reg     <= sec_cnt_next;
        end
    end

endmodule

>>> rtl/mmss_countdown_timer_with_lockout.sv
// top level of the mm:ss countdown timer with contestant lockout
// depends on mct_pkg, mct_keys and mct_core

// Each input transfer is one 1 ms tick carrying the three key levels; each one
// yields exactly one status transfer (digits, blink position, LEDs, beeper,
// counting). A tick is taken every clock cycle as long as the output register
// is empty or being drained, and its status appears in the output register on
// the next cycle: throughput is one tick per cycle, with the single state
// update done in the logic between the input handshake and the output
// register. Key 1 steps the edit cursor over the four digits, key 2 raises and
// a short key-3 press lowers the selected digit; with no digit selected a short
// key-3 press starts or pauses the countdown. While running, the first
// contestant key (1 or 2) lights its LED, stops the run and beeps for
// beep_ticks. At zero the beeper stays on and the LEDs chase. A long key-3
// press clears everything. Timing registers are written through the cfg
// channel, which is always ready; write them only while no tick is in flight.

module mmss_countdown_timer_with_lockout
    import mct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // tick input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // key_one_down, key_two_down, key_three_down, zeros
    // status output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // minutes_tens[4], minutes_ones[4],
                                                   // seconds_tens[3], seconds_ones[4],
                                                   // blanked_digit[3], leds_lit[4],
                                                   // beeper_on, counting
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [CFG_W-1:0]      long_press_reg;
    timer_cfg_t            timer_cfg_reg;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                  in_fire;
    key_t                  key;
    result_t               result;

    // tick is taken whenever the output slot frees up this cycle
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg                 <= LONG_PRESS_RST;
            timer_cfg_reg.beep_ticks       <= BEEP_RST;
            timer_cfg_reg.blink_half_ticks <= BLINK_HALF_RST;
            timer_cfg_reg.chase_step_ticks <= CHASE_STEP_RST;
            timer_cfg_reg.ticks_per_second <= TICKS_PER_S_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS:  long_press_reg                 <= cfg_data;
                REG_BEEP:        timer_cfg_reg.beep_ticks       <= cfg_data;
                REG_BLINK_HALF:  timer_cfg_reg.blink_half_ticks <= cfg_data;
                REG_CHASE_STEP:  timer_cfg_reg.chase_step_ticks <= cfg_data;
                REG_TICKS_PER_S: timer_cfg_reg.ticks_per_second <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mct_keys u_keys (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (in_fire),
        .key_one_down     (s_axis_tdata[0]),
        .key_two_down     (s_axis_tdata[1]),
        .key_three_down   (s_axis_tdata[2]),
        .long_press_ticks (long_press_reg),
        .key              (key)
    );

    mct_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (in_fire),
        .key    (key),
        .cfg    (timer_cfg_reg),
        .result (result)
    );

    // pack the status, first field lowest
    assign m_data_next = {result.counting, result.beeper_on, result.leds_lit,
                          result.blanked_digit, result.seconds_ones, result.seconds_tens,
                          result.minutes_ones, result.minutes_tens};

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (in_fire)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // every accepted tick leaves a status in the output register
    a_tick_gives_status : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_axis_tvalid)
        else $error("accepted tick produced no status");

    // digit ranges and blink position stay legal
    a_fields_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:8] <= 3'd5) && (m_axis_tdata[17:15] <= 3'd4))
        else $error("status field out of range");

    // a running countdown never has a digit under edit
    a_no_blink_while_running : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[23]) |-> (m_axis_tdata[17:15] == 3'd0))
        else $error("digit blanked while counting");

endmodule

>>> bench/mmss_countdown_timer_with_lockout_tb.sv
// self-checking bench for the mm:ss countdown timer with contestant lockout
// drives key ticks and register writes, predicts every status transfer in-bench
// depends on mct_pkg and mmss_countdown_timer_with_lockout

module mmss_countdown_timer_with_lockout_tb;

    import mct_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // key masks on the tick transfer, bit 0 is key 1
    localparam logic [2:0] K_NONE = 3'b000;
    localparam logic [2:0] K1     = 3'b001;
    localparam logic [2:0] K2     = 3'b010;
    localparam logic [2:0] K3     = 3'b100;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    mmss_countdown_timer_with_lockout u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // timing registers as the bench believes them to be
    logic [15:0] cfg_long_press = LONG_PRESS_RST;
    logic [15:0] cfg_beep       = BEEP_RST;
    logic [15:0] cfg_blink_half = BLINK_HALF_RST;
    logic [15:0] cfg_chase_step = CHASE_STEP_RST;
    logic [15:0] cfg_tps        = TICKS_PER_S_RST;

    // timer state, mirrored tick by tick
    logic [3:0]  tm_digit [4] = '{default: 4'd0};
    logic [2:0]  tm_cursor    = 3'd0;
    logic [12:0] tm_secs      = 13'd0;
    logic        tm_run       = 1'b0;
    logic        tm_armed     = 1'b0;
    logic        tm_started   = 1'b0;
    logic        tm_finished  = 1'b0;
    logic        tm_taken [2] = '{default: 1'b0};
    logic [3:0]  tm_leds      = 4'd0;
    logic [15:0] tm_beep_cnt  = 16'd0;
    logic        tm_beep      = 1'b0;
    logic [15:0] tm_blink_cnt = 16'd0;
    logic        tm_blink_on  = 1'b1;
    logic [15:0] tm_chase_cnt = 16'd0;
    logic [1:0]  tm_chase_idx = 2'd0;
    logic [15:0] tm_sec_cnt   = 16'd0;
    logic        tm_released  = 1'b1;
    logic        tm_long_seen = 1'b0;
    logic        tm_k3_held   = 1'b0;
    logic [15:0] tm_hold      = 16'd0;

    result_t expected_status [$];
    int      mismatches  = 0;
    int      ticks_sent  = 0;
    int      quiet_cycles = 0;
    bit      pace_on     = 1'b1;

    function automatic logic [3:0] digit_ceiling(input logic [1:0] pos);
        return (pos == SEC_TENS_POS) ? SEC_TENS_MAX : DIGIT_MAX;
    endfunction

    // first contestant key of a run wins, the other is locked out
    task automatic lock_contestant(input int who);
        tm_taken[who] = 1'b1;
        if (!tm_taken[1 - who])
        begin
            tm_run      = 1'b0;
            tm_leds     = tm_leds | (4'b0001 << who);
            tm_beep_cnt = cfg_beep;
            tm_beep     = 1'b1;
        end
    endtask

    // one 1 ms tick: key decode, control, chase latch, counters, countdown
    task automatic advance_timer(input logic [2:0] keys, output result_t st);
        key_t       key;
        logic       any_key;
        logic       editing;
        logic       racing;
        logic [1:0] pos;
        logic [3:0] bumped;
        key     = KEY_NONE;
        any_key = |keys;
        if (tm_released && any_key)
        begin
            tm_released  = 1'b0;
            tm_long_seen = 1'b0;
            if (keys[0])
                key = KEY_ONE;
            else if (keys[1])
                key = KEY_TWO;
            else
            begin
                tm_k3_held = 1'b1;
                tm_hold    = 16'd0;
            end
        end
        else if (!any_key)
        begin
            tm_released = 1'b1;
            // short press takes effect on release
            if (tm_k3_held && tm_hold < cfg_long_press && !tm_long_seen)
                key = KEY_THREE_SHORT;
            tm_k3_held = 1'b0;
        end
        if (tm_k3_held && tm_hold >= cfg_long_press && !tm_long_seen)
        begin
            key          = KEY_THREE_LONG;
            tm_long_seen = 1'b1;
        end

        pos     = tm_cursor[1:0] - 2'd1;
        editing = !tm_started && !tm_finished;
        racing  = tm_started && tm_armed && !tm_finished;
        case (key)
            KEY_ONE:
                if (editing)
                    tm_cursor = (tm_cursor == CURSOR_LAST) ? 3'd0 : tm_cursor + 3'd1;
                else if (racing)
                    lock_contestant(0);
            KEY_TWO:
                if (editing)
                begin
                    if (tm_cursor != 3'd0)
                    begin
                        bumped        = tm_digit[pos] + 4'd1;
                        tm_digit[pos] = (bumped > digit_ceiling(pos)) ? 4'd0 : bumped;
                    end
                end
                else if (racing)
                    lock_contestant(1);
            KEY_THREE_SHORT:
                if (tm_cursor == 3'd0)
                begin
                    if (!tm_armed)
                    begin
                        tm_secs = 13'(tm_digit[0] * 600 + tm_digit[1] * 60
                                      + tm_digit[2] * 10 + tm_digit[3]);
                        tm_started  = 1'b1;
                        tm_taken[0] = 1'b0;
                        tm_taken[1] = 1'b0;
                        tm_run      = 1'b1;
                        tm_armed    = 1'b1;
                    end
                    else
                    begin
                        tm_run     = 1'b0;
                        tm_armed   = 1'b0;
                        tm_started = 1'b1;
                        tm_leds    = 4'd0;
                    end
                end
                else
                    tm_digit[pos] = (tm_digit[pos] == 4'd0) ? digit_ceiling(pos)
                                                            : tm_digit[pos] - 4'd1;
            KEY_THREE_LONG:
            begin
                tm_digit    = '{default: 4'd0};
                tm_started  = 1'b0;
                tm_beep     = 1'b0;
                tm_run      = 1'b0;
                tm_finished = 1'b0;
                tm_armed    = 1'b0;
                tm_cursor   = 3'd0;
                tm_leds     = 4'd0;
            end
            default: ;
        endcase

        if (tm_finished)
            tm_leds = 4'b0001 << tm_chase_idx;

        tm_blink_cnt = tm_blink_cnt + 16'd1;
        if (tm_blink_cnt >= cfg_blink_half)
        begin
            tm_blink_cnt = 16'd0;
            tm_blink_on  = !tm_blink_on;
        end
        tm_chase_cnt = tm_chase_cnt + 16'd1;
        if (tm_chase_cnt >= cfg_chase_step)
        begin
            tm_chase_cnt = 16'd0;
            tm_chase_idx = tm_chase_idx + 2'd1;
        end
        if (tm_beep_cnt != 16'd0)
        begin
            tm_beep_cnt = tm_beep_cnt - 16'd1;
            if (tm_beep_cnt == 16'd0)
                tm_beep = 1'b0;
        end
        if (tm_k3_held && tm_hold != 16'hFFFF)
            tm_hold = tm_hold + 16'd1;

        // second counter keeps its count across start and pause
        if (tm_run)
        begin
            tm_sec_cnt = tm_sec_cnt + 16'd1;
            if (tm_sec_cnt >= cfg_tps)
            begin
                tm_sec_cnt = 16'd0;
                if (tm_secs != 13'd0)
                begin
                    tm_secs     = tm_secs - 13'd1;
                    tm_digit[0] = 4'(tm_secs / 600);
                    tm_digit[1] = 4'((tm_secs % 600) / 60);
                    tm_digit[2] = 4'((tm_secs % 60) / 10);
                    tm_digit[3] = 4'(tm_secs % 10);
                end
                if ((tm_digit[0] | tm_digit[1] | tm_digit[2] | tm_digit[3]) == 4'd0)
                begin
                    tm_beep     = 1'b1;
                    tm_finished = 1'b1;
                    tm_run      = 1'b0;
                end
            end
        end

        st.minutes_tens  = tm_digit[0];
        st.minutes_ones  = tm_digit[1];
        st.seconds_tens  = tm_digit[2][2:0];
        st.seconds_ones  = tm_digit[3];
        st.blanked_digit = (tm_cursor != 3'd0 && !tm_blink_on) ? tm_cursor : 3'd0;
        st.leds_lit      = tm_leds;
        st.beeper_on     = tm_beep;
        st.counting      = tm_run;
    endtask

    // one tick transfer; the status is predicted at the accepting edge
    task automatic send_tick(input logic [2:0] keys);
        int      gap;
        result_t st;
        gap = pace_on ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - 3){1'b0}}, keys};
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_timer(keys, st);
        expected_status.push_back(st);
        ticks_sent++;
    endtask

    task automatic press(input logic [2:0] keys, input int hold, input int rest);
        repeat (hold) send_tick(keys);
        repeat (rest) send_tick(K_NONE);
    endtask

    // register write, only once every tick in flight has come back
    task automatic write_timer_reg(input logic [CFG_INDEX_W-1:0] index,
                                   input logic [CFG_W-1:0] value);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_LONG_PRESS:  cfg_long_press = value;
            REG_BEEP:        cfg_beep       = value;
            REG_BLINK_HALF:  cfg_blink_half = value;
            REG_CHASE_STEP:  cfg_chase_step = value;
            REG_TICKS_PER_S: cfg_tps        = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] lp_ticks, input logic [15:0] bp_ticks,
                              input logic [15:0] bl_ticks, input logic [15:0] ch_ticks,
                              input logic [15:0] sec_ticks);
        write_timer_reg(REG_LONG_PRESS, lp_ticks);
        write_timer_reg(REG_BEEP, bp_ticks);
        write_timer_reg(REG_BLINK_HALF, bl_ticks);
        write_timer_reg(REG_CHASE_STEP, ch_ticks);
        write_timer_reg(REG_TICKS_PER_S, sec_ticks);
    endtask

    // key 3 released early enough to count as short, where that is possible
    task automatic tap_key_three();
        int hold;
        hold = (cfg_long_press > 1)
             ? $urandom_range(1, (cfg_long_press > 6) ? 6 : cfg_long_press - 1) : 1;
        press(K3, hold, $urandom_range(1, 3));
    endtask

    task automatic hold_key_three();
        if (cfg_long_press <= 40)
            press(K3, cfg_long_press + 1 + $urandom_range(0, 2), $urandom_range(1, 3));
        else
            tap_key_three();
    endtask

    // clear, set a few seconds, start and let it run out into the chase
    task automatic race_to_zero();
        int guard;
        if (cfg_long_press < 2 || cfg_long_press > 40 || cfg_tps > 8)
        begin
            tap_key_three();
            return;
        end
        hold_key_three();
        repeat (4) press(K1, 1, 1);
        repeat ($urandom_range(0, 2)) press(K2, 1, 1);
        press(K1, 1, 1);
        tap_key_three();
        guard = 0;
        while (!tm_finished && guard < 4 * cfg_tps + 8)
        begin
            send_tick(K_NONE);
            guard++;
        end
        press(K_NONE, 0, $urandom_range(2, 8));
    endtask

    task automatic play_episode();
        int steps;
        pace_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0, 1:
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 2))
                        0: press(K1, $urandom_range(1, 3), $urandom_range(1, 3));
                        1: press(K2, $urandom_range(1, 3), $urandom_range(1, 3));
                        default: tap_key_three();
                    endcase
                end
            2:
            begin
                // walk the cursor home, then start or pause
                steps = 0;
                while (tm_cursor != 3'd0 && steps < 5)
                begin
                    press(K1, 1, 1);
                    steps++;
                end
                tap_key_three();
            end
            3: press(K_NONE, 0, $urandom_range(1, 12));
            4: press($urandom_range(0, 1) ? K1 : K2, $urandom_range(1, 3), $urandom_range(1, 3));
            5: hold_key_three();
            6: race_to_zero();
            7: repeat ($urandom_range(1, 6)) send_tick(3'($urandom_range(0, 7)));
            8: tap_key_three();
            default: press(3'($urandom_range(3, 7)), $urandom_range(1, 4), $urandom_range(1, 3));
        endcase
    endtask

    task automatic run_episodes(input int n_ticks);
        int target;
        target = ticks_sent + n_ticks;
        while (ticks_sent < target)
            play_episode();
    endtask

    // reset timing: editing, digit wrap both ways, simultaneous key priority
    task automatic test_edit_at_reset();
        pace_on = 1'b1;
        press(K_NONE, 0, 2);
        press(K1 | K2 | K3, 1, 1);
        press(K3, 1, 1);
        press(K2, 1, 1);
        press(K2, 1, 1);
        press(K2 | K3, 1, 1);
        press(K1, 1, 1);
        press(K1, 1, 1);
        press(K3, 1, 1);
        press(K2, 1, 1);
        press(K3, 1, 1);
    endtask

    // start, contestant lockout, pause, restart and long-press clear
    task automatic test_race_and_lockout();
        set_timing(16'd3, 16'd2, 16'd2, 16'd1, 16'd1);
        pace_on = 1'b0;
        press(K1, 1, 1);
        press(K1, 1, 1);
        press(K3, 1, 1);
        press(K_NONE, 0, 3);
        press(K2, 1, 1);
        press(K1, 1, 2);
        pace_on = 1'b1;
        press(K3, 2, 1);
        press(K3, 1, 2);
        press(K1, 1, 1);
        press(K3, 5, 2);
    endtask

    task automatic test_register_extremes();
        set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        run_episodes(90);
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_episodes(60);
        set_timing(16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'd1);
        run_episodes(90);
    endtask

    task automatic test_random_sessions();
        repeat (6)
        begin
            set_timing(16'($urandom_range(2, 8)), 16'($urandom_range(1, 12)),
                       16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                       16'($urandom_range(1, 5)));
            run_episodes(110);
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // status sink with random back-pressure, checks each transfer in order
    initial
    begin : status_sink
        int      stall;
        result_t want;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = pace_on ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            if (expected_status.size() == 0)
            begin
                $error("status transfer with no tick waiting: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("minutes_tens",  want.minutes_tens,  m_axis_tdata[3:0]);
                check_field("minutes_ones",  want.minutes_ones,  m_axis_tdata[7:4]);
                check_field("seconds_tens",  want.seconds_tens,  m_axis_tdata[10:8]);
                check_field("seconds_ones",  want.seconds_ones,  m_axis_tdata[14:11]);
                check_field("blanked_digit", want.blanked_digit, m_axis_tdata[17:15]);
                check_field("leds_lit",      want.leds_lit,      m_axis_tdata[21:18]);
                check_field("beeper_on",     want.beeper_on,     m_axis_tdata[22]);
                check_field("counting",      want.counting,      m_axis_tdata[23]);
            end
            @(negedge clk);
        end
    end

    // watchdog: too long without any transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL mmss_countdown_timer_with_lockout");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_edit_at_reset();
        test_race_and_lockout();
        test_register_extremes();
        test_random_sessions();

        // drain, then give anything stray time to show up
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("PASS mmss_countdown_timer_with_lockout");
        else
            $display("FAIL mmss_countdown_timer_with_lockout");
        $finish;
    end

endmodule
